// ===== rtl/core/ortlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered route table package
// Widths, operation and status codes, and the request and response types
// shared by the ordered route table with longest prefix match.
// ----------------------------------------------------------------------------
package ortlpm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 32;
   localparam int PLEN_W      = 6;
   localparam int FUNC_W      = 3;
   localparam int STAT_W      = 2;

   localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_EXACT  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_LPM    = 3'd3;
   localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_MATCH = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] address;
      logic [PLEN_W-1:0] prefix_len;
      logic [IDX_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  match_index;
      logic [ADDR_W-1:0] match_address;
      logic [PLEN_W-1:0] match_prefix;
      logic [CNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [PLEN_W-1:0] prefix;
   } route_type;

   // A zero length covers no bits; anything from 32 up covers the whole address.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
      logic [ADDR_W-1:0] mask;
      if (plen == '0) begin
         mask = '0;
      end else if (plen >= PLEN_W'(ADDR_W)) begin
         mask = '1;
      end else begin
         mask = ~({ADDR_W{1'b1}} >> plen);
      end
      return mask;
   endfunction

endpackage

// ===== rtl/core/ordered_route_table_lpm_unit.sv =====
// ----------------------------------------------------------------------------
// Ordered route table with longest prefix match
// Holds IPv4 routes in insertion order in one synchronous memory. Supports
// append, delete with compaction, exact lookup, longest prefix lookup and
// read by position.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | req_data  (req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data  (rsp_type)
//
// Append, unused codes and error cases go straight to the done state. Lookups
// scan all stored routes, the memory read port scanning one entry per cycle;
// on an empty table they finish without a read. Read fetches the one entry at
// its position; delete at position P reads from P to the end and moves each
// later entry down one place, one entry moved per cycle through the read port.
// Reset clears the route count, the state and the valid flags; the memory holds no reset state.
// One request is in flight at a time; a finished response waits in the
// output register while rsp_stall is high and the next request is taken.
// ----------------------------------------------------------------------------
module ordered_route_table_lpm_unit
   import ortlpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   route_type route_mem [TABLE_DEPTH];

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   route_type         mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   route_type         rd_data_ff;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              found_ff, found_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [PLEN_W-1:0] res_pre_ff, res_pre_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0] cand_mask;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cand_mask = prefix_mask(rd_data_ff.prefix);

   // During compaction the write goes one entry below the entry just read,
   // while the read port is already two entries ahead, so the two never collide.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         route_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= route_mem[mem_raddr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_in      = 1'b0;
      pend_idx_in  = rd_ptr_ff[IDX_W-1:0];
      found_in     = found_ff;
      status_in    = status_ff;
      res_idx_in   = res_idx_ff;
      res_addr_in  = res_addr_ff;
      res_pre_in   = res_pre_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = pend_idx_ff - IDX_W'(1);
      mem_wdata    = rd_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = rd_ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.func;
               key_in      = req_data.address;
               start_in    = req_data.position;
               found_in    = 1'b0;
               status_in   = STAT_OK;
               res_idx_in  = '0;
               res_addr_in = '0;
               res_pre_in  = '0;
               state_in    = ST_DONE;
               unique case (req_data.func) inside
                  FN_APPEND: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        status_in = STAT_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = count_ff[IDX_W-1:0];
                        mem_wdata   = '{address: req_data.address,
                                        prefix: req_data.prefix_len};
                        res_idx_in  = count_ff[IDX_W-1:0];
                        res_addr_in = req_data.address;
                        res_pre_in  = req_data.prefix_len;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  FN_DELETE, FN_READ: begin
                     if (CNT_W'(req_data.position) >= count_ff) begin
                        status_in = STAT_PAST_END;
                     end else begin
                        rd_ptr_in = CNT_W'(req_data.position);
                        end_in    = (req_data.func == FN_READ) ?
                                    CNT_W'(req_data.position) + CNT_W'(1) : count_ff;
                        state_in  = ST_SCAN;
                     end
                  end
                  FN_EXACT, FN_LPM: begin
                     rd_ptr_in = '0;
                     end_in    = count_ff;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_ptr_ff != end_ff) begin
               mem_re      = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               case (op_ff)
                  FN_EXACT: begin
                     if (!found_ff && rd_data_ff.address == key_ff) begin
                        found_in    = 1'b1;
                        res_idx_in  = pend_idx_ff;
                        res_addr_in = rd_data_ff.address;
                        res_pre_in  = rd_data_ff.prefix;
                     end
                  end
                  FN_LPM: begin
                     // res_pre_ff starts at zero, so a zero-length route never wins.
                     if (rd_data_ff.prefix > res_pre_ff &&
                         (rd_data_ff.address & cand_mask) == (key_ff & cand_mask)) begin
                        found_in    = 1'b1;
                        res_idx_in  = pend_idx_ff;
                        res_addr_in = rd_data_ff.address;
                        res_pre_in  = rd_data_ff.prefix;
                     end
                  end
                  FN_DELETE: begin
                     if (pend_idx_ff == start_ff) begin
                        res_idx_in  = pend_idx_ff;
                        res_addr_in = rd_data_ff.address;
                        res_pre_in  = rd_data_ff.prefix;
                     end else begin
                        mem_we = 1'b1;
                     end
                  end
                  default: begin
                     res_idx_in  = pend_idx_ff;
                     res_addr_in = rd_data_ff.address;
                     res_pre_in  = rd_data_ff.prefix;
                  end
               endcase
            end else if (rd_ptr_ff == end_ff) begin
               state_in = ST_DONE;
               if ((op_ff == FN_EXACT || op_ff == FN_LPM) && !found_ff) begin
                  status_in = STAT_NO_MATCH;
               end
               if (op_ff == FN_DELETE) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.match_index   = res_idx_ff;
               rsp_data_in.match_address = res_addr_ff;
               rsp_data_in.match_prefix  = res_pre_ff;
               rsp_data_in.entry_count   = count_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      rd_ptr_ff   <= rd_ptr_in;
      pend_idx_ff <= pend_idx_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      res_idx_ff  <= res_idx_in;
      res_addr_ff <= res_addr_in;
      res_pre_ff  <= res_pre_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count above table depth");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != ST_IDLE)
      else $error("accepted request did not leave idle");

   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_SCAN)
      else $error("memory read data pending outside scan");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised without a finished request");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STAT_OK) |->
         (rsp_data_ff.match_index == '0 && rsp_data_ff.match_address == '0 &&
          rsp_data_ff.match_prefix == '0))
      else $error("error response carries entry fields");

endmodule
